// ----- sv/spm_pkg.sv -----
// Package for the spindle speed to PWM block.
// Holds the configuration types, register codes, sequencer states and duty clipping.
// Used by every module of the block; depends on nothing.
`default_nettype none

package spm_pkg;

  localparam int unsigned DUTY_BITS = 16;
  localparam int unsigned SPEED_W   = 20;
  localparam int unsigned DUTY_W    = 16;
  localparam int unsigned SLOPE_W   = 32;
  localparam int unsigned OVR_W     = 8;
  localparam int unsigned ADDR_W    = 5;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned MUL_W     = 32;
  localparam int unsigned PROD_W    = 2 * MUL_W;
  localparam int unsigned RAW_W     = SPEED_W + OVR_W;
  localparam int unsigned SCALED_W  = 22;
  localparam int unsigned SUM_W     = RAW_W + 1;
  localparam int unsigned SLOPE_FRAC = 24;

  // floor(x / 100) == (x * RECIP_100) >> RECIP_SHIFT for every x below 2^RAW_W
  localparam int unsigned RECIP_SHIFT = 35;
  localparam logic [MUL_W-1:0] RECIP_100 = 32'd343597384;

  localparam logic [SUM_W-1:0] DUTY_TOP = SUM_W'((64'd1 << DUTY_BITS) - 64'd1);

  localparam logic [1:0] CMD_OFF = 2'd0;

  localparam logic [2:0] REG_MIN_SPEED  = 3'd0;
  localparam logic [2:0] REG_MAX_SPEED  = 3'd1;
  localparam logic [2:0] REG_DUTY_SLOPE = 3'd2;
  localparam logic [2:0] REG_LASER_MODE = 3'd3;
  localparam logic [2:0] REG_DUTY_OFF   = 3'd4;
  localparam logic [2:0] REG_DUTY_MIN   = 3'd5;
  localparam logic [2:0] REG_DUTY_MAX   = 3'd6;
  localparam logic [2:0] REG_DROP_EN    = 3'd7;

  typedef struct packed {
    logic [SPEED_W-1:0] min_speed;
    logic [SPEED_W-1:0] max_speed;
    logic [SLOPE_W-1:0] duty_slope;
    logic               laser_mode;
    logic [DUTY_W-1:0]  duty_off;
    logic [DUTY_W-1:0]  duty_min;
    logic [DUTY_W-1:0]  duty_max;
    logic               drop_enable_at_off;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    min_speed:          '0,
    max_speed:          SPEED_W'(16000),
    duty_slope:         '0,
    laser_mode:         1'b0,
    duty_off:           '0,
    duty_min:           DUTY_W'(1),
    duty_max:           DUTY_W'(1000),
    drop_enable_at_off: 1'b0
  };

  typedef struct packed {
    logic             en;
    logic [MUL_W-1:0] a;
    logic [MUL_W-1:0] b;
  } mul_req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCALE,
    ST_RECIP,
    ST_SPLIT,
    ST_SLOPE,
    ST_WRITE
  } state_e;

  function automatic logic [DUTY_W-1:0] clip_duty(input logic [SUM_W-1:0] v);
    logic [SUM_W-1:0] c;
    c = (v > DUTY_TOP) ? DUTY_TOP : v;
    return c[DUTY_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- sv/spm_regs.sv -----
// Configuration register file with an APB-style access port.
// Depends on spm_pkg for the register codes and the configuration struct.
`default_nettype none

module spm_regs (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [spm_pkg::ADDR_W-1:0] paddr,
  input  wire logic [spm_pkg::DATA_W-1:0] pwdata,
  output logic      [spm_pkg::DATA_W-1:0] prdata,
  output logic                            pready,
  output spm_pkg::cfg_t                   cfg_o
);
  import spm_pkg::*;

  cfg_t       cfg_q;
  logic [2:0] idx;
  logic       wr_en;

  assign idx    = paddr[ADDR_W-1:2];
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (wr_en) begin
      unique case (idx)
        REG_MIN_SPEED:  cfg_q.min_speed          <= pwdata[SPEED_W-1:0];
        REG_MAX_SPEED:  cfg_q.max_speed          <= pwdata[SPEED_W-1:0];
        REG_DUTY_SLOPE: cfg_q.duty_slope         <= pwdata[SLOPE_W-1:0];
        REG_LASER_MODE: cfg_q.laser_mode         <= pwdata[0];
        REG_DUTY_OFF:   cfg_q.duty_off           <= pwdata[DUTY_W-1:0];
        REG_DUTY_MIN:   cfg_q.duty_min           <= pwdata[DUTY_W-1:0];
        REG_DUTY_MAX:   cfg_q.duty_max           <= pwdata[DUTY_W-1:0];
        REG_DROP_EN:    cfg_q.drop_enable_at_off <= pwdata[0];
        default:        cfg_q                    <= cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_MIN_SPEED:  prdata = DATA_W'(cfg_q.min_speed);
      REG_MAX_SPEED:  prdata = DATA_W'(cfg_q.max_speed);
      REG_DUTY_SLOPE: prdata = DATA_W'(cfg_q.duty_slope);
      REG_LASER_MODE: prdata = DATA_W'(cfg_q.laser_mode);
      REG_DUTY_OFF:   prdata = DATA_W'(cfg_q.duty_off);
      REG_DUTY_MIN:   prdata = DATA_W'(cfg_q.duty_min);
      REG_DUTY_MAX:   prdata = DATA_W'(cfg_q.duty_max);
      REG_DROP_EN:    prdata = DATA_W'(cfg_q.drop_enable_at_off);
      default:        prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ----- sv/spm_mul.sv -----
// Shared 32 by 32 unsigned multiplier with a registered product.
// Depends on spm_pkg for the request struct and widths.
`default_nettype none

module spm_mul (
  input  wire logic                       clk_i,
  input  spm_pkg::mul_req_t               req_i,
  output logic      [spm_pkg::PROD_W-1:0] prod_o
);
  import spm_pkg::*;

  logic [PROD_W-1:0] prod_q;
  logic [PROD_W-1:0] prod_d;

  assign prod_d = PROD_W'(req_i.a) * PROD_W'(req_i.b);
  assign prod_o = prod_q;

  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      prod_q <= prod_d;
    end
  end

endmodule

`default_nettype wire

// ----- sv/spm_core.sv -----
// Sequencer, held spindle state and output register.
// Drives the shared multiplier for override scaling, divide by 100 and slope.
// Depends on spm_pkg.
`default_nettype none

module spm_core (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  spm_pkg::cfg_t                    cfg_i,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [1:0]                  command_i,
  input  wire logic [spm_pkg::SPEED_W-1:0] requested_speed_i,
  input  wire logic [spm_pkg::OVR_W-1:0]   override_percent_i,
  input  wire logic                        abort_active_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic      [spm_pkg::DUTY_W-1:0]  duty_value_o,
  output logic                             turn_ccw_o,
  output logic                             spindle_on_o,
  output logic      [spm_pkg::SPEED_W-1:0] actual_speed_o,
  output logic                             was_applied_o,
  output spm_pkg::mul_req_t                mul_req_o,
  input  wire logic [spm_pkg::PROD_W-1:0]  mul_prod_i
);
  import spm_pkg::*;

  state_e state_q, state_d;

  logic                ccw_q, run_q, abort_q;
  logic [SPEED_W-1:0]  req_q;
  logic [OVR_W-1:0]    ovr_q;
  logic [SCALED_W-1:0] scaled_q;
  logic [SPEED_W-1:0]  diff_q;
  logic [DUTY_W-1:0]   held_duty_q;
  logic                held_dir_q, held_en_q;
  logic [SPEED_W-1:0]  held_speed_q;
  logic                out_valid_q, applied_q;

  logic                accept, load;
  logic [SCALED_W-1:0] scaled_d;
  logic [SUM_W-1:0]    lin_sum, duty_sel;
  logic [DUTY_W-1:0]   duty_new, off_clip;
  logic [SPEED_W-1:0]  speed_new;

  assign accept   = in_valid_i & in_ready_o;
  assign load     = (state_q == ST_WRITE) & (~out_valid_q | out_ready_i);
  assign scaled_d = mul_prod_i[RECIP_SHIFT +: SCALED_W];
  assign lin_sum  = SUM_W'(mul_prod_i[SLOPE_FRAC +: RAW_W]) + SUM_W'(cfg_i.duty_min);
  assign off_clip = clip_duty(SUM_W'(cfg_i.duty_off));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (abort_active_i || command_i == CMD_OFF) ? ST_WRITE : ST_SCALE;
        end
      end
      ST_SCALE: state_d = ST_RECIP;
      ST_RECIP: state_d = ST_SPLIT;
      ST_SPLIT: state_d = ST_SLOPE;
      ST_SLOPE: state_d = ST_WRITE;
      ST_WRITE: begin
        if (load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    mul_req_o  = '0;
    unique case (state_q)
      ST_IDLE:  in_ready_o = 1'b1;
      ST_SCALE: begin
        mul_req_o.en = 1'b1;
        mul_req_o.a  = MUL_W'(req_q);
        mul_req_o.b  = MUL_W'(ovr_q);
      end
      ST_RECIP: begin
        mul_req_o.en = 1'b1;
        mul_req_o.a  = MUL_W'(mul_prod_i[RAW_W-1:0]);
        mul_req_o.b  = RECIP_100;
      end
      ST_SLOPE: begin
        mul_req_o.en = 1'b1;
        mul_req_o.a  = MUL_W'(diff_q);
        mul_req_o.b  = cfg_i.duty_slope;
      end
      ST_SPLIT, ST_WRITE: begin
        mul_req_o = '0;
      end
      default: begin
        mul_req_o = '0;
      end
    endcase
  end

  always_comb begin
    priority if (cfg_i.min_speed >= cfg_i.max_speed
                 || scaled_q >= SCALED_W'(cfg_i.max_speed)) begin
      duty_sel  = SUM_W'(cfg_i.duty_max);
      speed_new = cfg_i.max_speed;
    end else if (scaled_q == '0) begin
      duty_sel  = SUM_W'(cfg_i.duty_off);
      speed_new = '0;
    end else if (scaled_q <= SCALED_W'(cfg_i.min_speed)) begin
      duty_sel  = SUM_W'(cfg_i.duty_min);
      speed_new = cfg_i.min_speed;
    end else begin
      duty_sel  = lin_sum;
      speed_new = scaled_q[SPEED_W-1:0];
    end
    duty_new = clip_duty(duty_sel);
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ccw_q   <= command_i[1];
      run_q   <= (command_i != CMD_OFF);
      abort_q <= abort_active_i;
      req_q   <= (cfg_i.laser_mode && command_i[1]) ? '0 : requested_speed_i;
      ovr_q   <= override_percent_i;
    end
    if (state_q == ST_SPLIT) begin
      scaled_q <= scaled_d;
      diff_q   <= scaled_d[SPEED_W-1:0] - cfg_i.min_speed;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      held_duty_q  <= clip_duty(SUM_W'(CFG_RESET.duty_off));
      held_dir_q   <= 1'b0;
      held_en_q    <= 1'b0;
      held_speed_q <= '0;
      out_valid_q  <= 1'b0;
      applied_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load) begin
        out_valid_q <= 1'b1;
        applied_q   <= ~abort_q;
        if (!abort_q) begin
          if (!run_q) begin
            held_duty_q  <= off_clip;
            held_en_q    <= 1'b0;
            held_speed_q <= '0;
          end else begin
            held_dir_q   <= ccw_q;
            held_duty_q  <= duty_new;
            held_speed_q <= speed_new;
            held_en_q    <= ~(cfg_i.drop_enable_at_off && duty_new == off_clip);
          end
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign duty_value_o   = held_duty_q;
  assign turn_ccw_o     = held_dir_q;
  assign spindle_on_o   = held_en_q;
  assign actual_speed_o = held_speed_q;
  assign was_applied_o  = applied_q;

endmodule

`default_nettype wire

// ----- sv/spindle_rpm_to_pwm_control.sv -----
// Spindle speed command to PWM compare value, top level.
// Depends on spm_pkg, spm_regs, spm_mul and spm_core.
//
// One command at a time. A running command (clockwise or counter-clockwise, no
// abort) goes after acceptance through three passes of the single shared 32x32
// multiplier (override scaling, divide by 100 via reciprocal, slope), followed by
// an operand split step and an output load step. After the load the sequencer
// returns to idle, and only there is the next command accepted. An off or aborted
// command goes from acceptance straight to the output load step. The result sits
// in an output register, so a new command is accepted while the previous result
// waits. A result is loaded only once the register is free, and the sequencer
// holds in its load step for as long as the receiver stalls. Configuration writes
// land at byte address 4*index and are taken at any time.
`default_nettype none

module spindle_rpm_to_pwm_control (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [spm_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [spm_pkg::DATA_W-1:0]  pwdata,
  output logic      [spm_pkg::DATA_W-1:0]  prdata,
  output logic                             pready,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [1:0]                  command_i,
  input  wire logic [spm_pkg::SPEED_W-1:0] requested_speed_i,
  input  wire logic [spm_pkg::OVR_W-1:0]   override_percent_i,
  input  wire logic                        abort_active_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic      [spm_pkg::DUTY_W-1:0]  duty_value_o,
  output logic                             turn_ccw_o,
  output logic                             spindle_on_o,
  output logic      [spm_pkg::SPEED_W-1:0] actual_speed_o,
  output logic                             was_applied_o
);
  import spm_pkg::*;

  cfg_t              cfg;
  mul_req_t          mul_req;
  logic [PROD_W-1:0] mul_prod;

  spm_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  spm_mul u_mul (
    .clk_i  (clk_i),
    .req_i  (mul_req),
    .prod_o (mul_prod)
  );

  spm_core u_core (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_i              (cfg),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .command_i          (command_i),
    .requested_speed_i  (requested_speed_i),
    .override_percent_i (override_percent_i),
    .abort_active_i     (abort_active_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .duty_value_o       (duty_value_o),
    .turn_ccw_o         (turn_ccw_o),
    .spindle_on_o       (spindle_on_o),
    .actual_speed_o     (actual_speed_o),
    .was_applied_o      (was_applied_o),
    .mul_req_o          (mul_req),
    .mul_prod_i         (mul_prod)
  );

endmodule

`default_nettype wire

// ----- sv/spm_checker.sv -----
// Port-level checks for the spindle speed to PWM block, bound to the top level.
// Depends on spm_pkg for field widths.
`default_nettype none

module spm_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        in_valid_i,
  input wire logic                        in_ready_o,
  input wire logic                        out_valid_o,
  input wire logic                        out_ready_i,
  input wire logic [spm_pkg::DUTY_W-1:0]  duty_value_o,
  input wire logic [spm_pkg::SPEED_W-1:0] actual_speed_o,
  input wire logic                        was_applied_o
);
  import spm_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped before it was taken");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      $stable(duty_value_o) && $stable(actual_speed_o) && $stable(was_applied_o))
    else $error("stalled result changed");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second item accepted while one is in work");

  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !$rose(out_valid_o))
    else $error("result appeared one cycle after acceptance");

endmodule

bind spindle_rpm_to_pwm_control spm_checker u_spm_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .duty_value_o   (duty_value_o),
  .actual_speed_o (actual_speed_o),
  .was_applied_o  (was_applied_o)
);

`default_nettype wire

// ----- tb/tb_spindle_rpm_to_pwm_control.sv -----
// Testbench for spindle_rpm_to_pwm_control: directed and random spindle commands are
// checked against an in-bench duty and speed predictor across many register setups.
// Depends on spm_pkg and the spindle_rpm_to_pwm_control RTL.
module tb_spindle_rpm_to_pwm_control;
  import spm_pkg::*;

  localparam logic [1:0] CMD_CW      = 2'd1;
  localparam logic [1:0] CMD_CCW     = 2'd2;
  localparam logic [1:0] CMD_CCW_ALT = 2'd3;
  localparam logic [63:0] DUTY_CEIL  = (64'd1 << DUTY_BITS) - 64'd1;
  localparam logic [SPEED_W-1:0] SPEED_TOP = '1;

  typedef struct packed {
    logic [DUTY_W-1:0]  duty;
    logic               ccw;
    logic               on;
    logic [SPEED_W-1:0] speed;
    logic               applied;
  } spindle_out_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [DATA_W-1:0]   pwdata = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic [1:0]          command_i = '0;
  logic [SPEED_W-1:0]  requested_speed_i = '0;
  logic [OVR_W-1:0]    override_percent_i = '0;
  logic                abort_active_i = 1'b0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [DUTY_W-1:0]   duty_value_o;
  logic                turn_ccw_o;
  logic                spindle_on_o;
  logic [SPEED_W-1:0]  actual_speed_o;
  logic                was_applied_o;

  cfg_t                cfg_shadow = CFG_RESET;
  logic [DUTY_W-1:0]   held_duty = '0;
  logic                held_ccw = 1'b0;
  logic                held_on = 1'b0;
  logic [SPEED_W-1:0]  held_speed = '0;

  spindle_out_t        pending_outputs[$];
  int                  mismatch_count = 0;
  int                  rx_gap = 0;
  bit                  rx_block = 1'b0;
  bit                  rx_steady = 1'b0;
  bit                  tx_steady = 1'b0;

  spindle_rpm_to_pwm_control i_dut (.*);

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic [DUTY_W-1:0] saturate_duty(input logic [63:0] v);
    return (v > DUTY_CEIL) ? DUTY_CEIL[DUTY_W-1:0] : v[DUTY_W-1:0];
  endfunction

  function automatic spindle_out_t predict_spindle_output(
      input logic [1:0] cmd, input logic [SPEED_W-1:0] spd,
      input logic [OVR_W-1:0] ovr, input logic abt);
    logic [63:0] req;
    logic [63:0] scaled;
    logic [63:0] duty;
    if (!abt) begin
      if (cmd == CMD_OFF) begin
        held_duty  = saturate_duty(64'(cfg_shadow.duty_off));
        held_on    = 1'b0;
        held_speed = '0;
      end else begin
        held_ccw = cmd[1];
        req = (cfg_shadow.laser_mode && cmd[1]) ? 64'd0 : 64'(spd);
        scaled = (req * 64'(ovr)) / 64'd100;
        if (cfg_shadow.min_speed >= cfg_shadow.max_speed ||
            scaled >= 64'(cfg_shadow.max_speed)) begin
          held_speed = cfg_shadow.max_speed;
          duty = 64'(cfg_shadow.duty_max);
        end else if (scaled == 64'd0) begin
          held_speed = '0;
          duty = 64'(cfg_shadow.duty_off);
        end else if (scaled <= 64'(cfg_shadow.min_speed)) begin
          held_speed = cfg_shadow.min_speed;
          duty = 64'(cfg_shadow.duty_min);
        end else begin
          held_speed = scaled[SPEED_W-1:0];
          duty = (((scaled - 64'(cfg_shadow.min_speed)) * 64'(cfg_shadow.duty_slope))
                  >> SLOPE_FRAC) + 64'(cfg_shadow.duty_min);
        end
        held_duty = saturate_duty(duty);
        held_on = !(cfg_shadow.drop_enable_at_off &&
                    held_duty == saturate_duty(64'(cfg_shadow.duty_off)));
      end
    end
    return {held_duty, held_ccw, held_on, held_speed, !abt};
  endfunction

  always @(posedge clk_i) begin
    int gap;
    if (rx_block) begin
      out_ready_i <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap <= rx_gap - 1;
      out_ready_i <= 1'b0;
    end else if (out_ready_i && out_valid_o) begin
      gap = rx_steady ? 0 : $urandom_range(0, 4);
      rx_gap <= gap;
      out_ready_i <= (gap == 0);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    spindle_out_t got;
    spindle_out_t want;
    if (out_valid_o && out_ready_i) begin
      got = {duty_value_o, turn_ccw_o, spindle_on_o, actual_speed_o, was_applied_o};
      if (pending_outputs.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected item: duty %0d ccw %0b on %0b speed %0d applied %0b",
                   got.duty, got.ccw, got.on, got.speed, got.applied);
      end else begin
        want = pending_outputs.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $write("mismatch: duty %0d/%0d ccw %0b/%0b on %0b/%0b speed %0d/%0d",
                   want.duty, got.duty, want.ccw, got.ccw, want.on, got.on,
                   want.speed, got.speed);
            $display(" applied %0b/%0b (expected/actual)", want.applied, got.applied);
          end
        end
      end
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [DATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_MIN_SPEED:  cfg_shadow.min_speed          = val[SPEED_W-1:0];
      REG_MAX_SPEED:  cfg_shadow.max_speed          = val[SPEED_W-1:0];
      REG_DUTY_SLOPE: cfg_shadow.duty_slope         = val[SLOPE_W-1:0];
      REG_LASER_MODE: cfg_shadow.laser_mode         = val[0];
      REG_DUTY_OFF:   cfg_shadow.duty_off           = val[DUTY_W-1:0];
      REG_DUTY_MIN:   cfg_shadow.duty_min           = val[DUTY_W-1:0];
      REG_DUTY_MAX:   cfg_shadow.duty_max           = val[DUTY_W-1:0];
      REG_DROP_EN:    cfg_shadow.drop_enable_at_off = val[0];
      default: ;
    endcase
  endtask

  task automatic load_setup(input logic [SPEED_W-1:0] lo, input logic [SPEED_W-1:0] hi,
                            input logic [SLOPE_W-1:0] slope, input logic laser,
                            input logic [DUTY_W-1:0] doff, input logic [DUTY_W-1:0] dlo,
                            input logic [DUTY_W-1:0] dhi, input logic drop);
    write_reg(REG_MIN_SPEED, DATA_W'(lo));
    write_reg(REG_MAX_SPEED, DATA_W'(hi));
    write_reg(REG_DUTY_SLOPE, DATA_W'(slope));
    write_reg(REG_LASER_MODE, DATA_W'(laser));
    write_reg(REG_DUTY_OFF, DATA_W'(doff));
    write_reg(REG_DUTY_MIN, DATA_W'(dlo));
    write_reg(REG_DUTY_MAX, DATA_W'(dhi));
    write_reg(REG_DROP_EN, DATA_W'(drop));
  endtask

  task automatic send_cmd(input logic [1:0] cmd, input logic [SPEED_W-1:0] spd,
                          input logic [OVR_W-1:0] ovr, input logic abt);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i         <= 1'b1;
    command_i          <= cmd;
    requested_speed_i  <= spd;
    override_percent_i <= ovr;
    abort_active_i     <= abt;
    do @(posedge clk_i); while (!in_ready_o);
    pending_outputs.push_back(predict_spindle_output(cmd, spd, ovr, abt));
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic send_random_command();
    logic [1:0]         cmd;
    logic [SPEED_W-1:0] spd;
    logic [OVR_W-1:0]   ovr;
    logic               abt;
    int unsigned        pick;
    int unsigned        reach;
    pick = $urandom_range(0, 19);
    cmd = (pick < 3) ? CMD_OFF : (pick < 11) ? CMD_CW : (pick < 18) ? CMD_CCW : CMD_CCW_ALT;
    reach = cfg_shadow.max_speed + cfg_shadow.max_speed / 4 + 16;
    if (reach > SPEED_TOP) reach = SPEED_TOP;
    case ($urandom_range(0, 5))
      0: spd = SPEED_W'($urandom);
      1: begin
        case ($urandom_range(0, 3))
          0: spd = cfg_shadow.min_speed;
          1: spd = cfg_shadow.min_speed + SPEED_W'(1);
          2: spd = cfg_shadow.max_speed - SPEED_W'(1);
          default: spd = cfg_shadow.max_speed;
        endcase
      end
      default: spd = SPEED_W'($urandom_range(0, reach));
    endcase
    case ($urandom_range(0, 3))
      0: ovr = 8'd100;
      1, 2: ovr = OVR_W'($urandom_range(10, 200));
      default: ovr = OVR_W'($urandom);
    endcase
    abt = ($urandom_range(0, 9) == 0);
    send_cmd(cmd, spd, ovr, abt);
  endtask

  task automatic load_random_setup();
    logic [SPEED_W-1:0] lo;
    logic [SPEED_W-1:0] hi;
    logic [DUTY_W-1:0]  dlo;
    logic [DUTY_W-1:0]  dhi;
    logic [DUTY_W-1:0]  doff;
    logic [SLOPE_W-1:0] slope;
    logic [63:0]        span;
    case ($urandom_range(0, 5))
      0: begin
        lo = SPEED_W'($urandom);
        hi = SPEED_W'($urandom);
        dlo = DUTY_W'($urandom);
        dhi = DUTY_W'($urandom);
        slope = $urandom;
      end
      1: begin
        lo = $urandom_range(0, 1) ? SPEED_TOP : '0;
        hi = $urandom_range(0, 1) ? SPEED_TOP : '0;
        dlo = $urandom_range(0, 1) ? '1 : '0;
        dhi = $urandom_range(0, 1) ? '1 : '0;
        slope = $urandom_range(0, 1) ? '1 : '0;
      end
      default: begin
        lo = SPEED_W'($urandom_range(0, 20000));
        hi = lo + SPEED_W'($urandom_range(1, 300000));
        dlo = DUTY_W'($urandom_range(0, 2000));
        dhi = DUTY_W'($urandom_range(dlo, 65535));
        span = ((64'(dhi) - 64'(dlo)) << SLOPE_FRAC) / (64'(hi) - 64'(lo));
        slope = span[SLOPE_W-1:0];
        if ($urandom_range(0, 3) == 0) slope = slope + $urandom_range(0, 1 << 24);
      end
    endcase
    case ($urandom_range(0, 3))
      0: doff = '0;
      1: doff = dlo;
      2: doff = dhi;
      default: doff = DUTY_W'($urandom);
    endcase
    load_setup(lo, hi, slope, 1'($urandom), doff, dlo, dhi, 1'($urandom));
  endtask

  task automatic hold_receiver(input int cycles);
    rx_block <= 1'b1;
    for (int n = 0; n < cycles; n++) @(posedge clk_i);
    rx_block <= 1'b0;
  endtask

  task automatic test_reset_setup();
    send_cmd(CMD_CW, 20'd8000, 8'd100, 1'b0);
    send_cmd(CMD_CCW, SPEED_TOP, 8'd255, 1'b0);
    send_cmd(CMD_CCW_ALT, 20'd0, 8'd100, 1'b0);
    send_cmd(CMD_CW, 20'd5, 8'd10, 1'b0);
    send_cmd(CMD_CW, 20'd1000, 8'd0, 1'b0);
    send_cmd(CMD_OFF, SPEED_TOP, 8'd200, 1'b1);
    send_cmd(CMD_OFF, 20'd0, 8'd100, 1'b0);
    wait_idle();
  endtask

  task automatic test_linear_range();
    load_setup(20'd1600, 20'd384000,
               32'(((64'd4000 - 64'd50) << SLOPE_FRAC) / (64'd384000 - 64'd1600)),
               1'b1, 16'd0, 16'd50, 16'd4000, 1'b1);
    send_cmd(CMD_CW, 20'd1599, 8'd100, 1'b0);
    send_cmd(CMD_CW, 20'd1600, 8'd100, 1'b0);
    send_cmd(CMD_CW, 20'd1601, 8'd100, 1'b0);
    send_cmd(CMD_CW, 20'd200000, 8'd100, 1'b0);
    send_cmd(CMD_CW, 20'd383999, 8'd100, 1'b0);
    send_cmd(CMD_CW, 20'd384000, 8'd100, 1'b0);
    send_cmd(CMD_CW, 20'd300000, 8'd200, 1'b0);
    send_cmd(CMD_CCW, 20'd200000, 8'd100, 1'b0);
    send_cmd(CMD_CW, 20'd100000, 8'd150, 1'b1);
    send_cmd(CMD_CCW_ALT, 20'd50000, 8'd100, 1'b0);
    send_cmd(CMD_OFF, 20'd50000, 8'd100, 1'b0);
    wait_idle();
  endtask

  task automatic test_register_extremes();
    load_setup(SPEED_TOP, 20'd0, 32'd0, 1'b0, 16'd7, 16'd9, 16'd11, 1'b0);
    send_cmd(CMD_CW, 20'd1000, 8'd100, 1'b0);
    wait_idle();
    load_setup(20'd0, SPEED_TOP, '1, 1'b0, '1, '1, '1, 1'b1);
    send_cmd(CMD_CW, 20'd1, 8'd100, 1'b0);
    send_cmd(CMD_CCW, 20'd3000, 8'd100, 1'b0);
    send_cmd(CMD_CW, SPEED_TOP, 8'd255, 1'b0);
    send_cmd(CMD_CCW, 20'd0, 8'd100, 1'b0);
    wait_idle();
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 10; phase++) begin
      load_random_setup();
      rx_steady = (phase == 3);
      tx_steady = (phase == 3);
      repeat (130) send_random_command();
      wait_idle();
    end
    rx_steady = 1'b0;
    tx_steady = 1'b0;
  endtask

  task automatic test_backpressure();
    load_random_setup();
    fork
      hold_receiver(300);
      repeat (40) send_random_command();
    join
    wait_idle();
    repeat (20) send_random_command();
    wait_idle();
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_setup();
    test_linear_range();
    test_register_extremes();
    test_random_traffic();
    test_backpressure();
    if (mismatch_count == 0 && pending_outputs.size() == 0) begin
      $display("tb_spindle_rpm_to_pwm_control: clean");
    end else begin
      $display("tb_spindle_rpm_to_pwm_control: errors");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("tb_spindle_rpm_to_pwm_control: errors");
    $finish;
  end

endmodule
